@@ sv/ufc_pkg.sv @@
`timescale 1ns / 1ps

package ufc_pkg;

	// Default ring depths; each ring keeps at most depth minus one bytes.
	localparam int RX_DEPTH_DEF = 128;
	localparam int TX_DEPTH_DEF = 128;

	// Request codes
	localparam logic [2:0] REQ_HOST_READ  = 3'd0;
	localparam logic [2:0] REQ_HOST_WRITE = 3'd1;
	localparam logic [2:0] REQ_LINE_BYTE  = 3'd2;
	localparam logic [2:0] REQ_TX_DONE    = 3'd3;
	localparam logic [2:0] REQ_RX_ERROR   = 3'd4;
	localparam logic [2:0] REQ_RESTART    = 3'd5;

	// Recorded error codes
	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_FRAMING = 3'd1;
	localparam logic [2:0] ERR_PARITY  = 3'd2;
	localparam logic [2:0] ERR_OVERRUN = 3'd3;
	localparam logic [2:0] ERR_UNKNOWN = 3'd4;

	// Outcome of one request, decided when it is accepted. Bytes read from
	// the rings arrive in the following cycle and are merged in by the top level.
	typedef struct packed {
		logic        ok;
		logic        use_rx;     // read_byte comes from the receive ring
		logic        use_tx;     // shift_byte comes from the transmit ring
		logic        shift;
		logic [7:0]  byte_val;   // direct hand-off byte, zero otherwise
		logic        idle;
		logic [2:0]  err_code;
		logic [15:0] err_total;
	} step_t;

endpackage

@@ sv/ufc_ring_mem.sv @@
`timescale 1ns / 1ps

module ufc_ring_mem #(
	parameter int DEPTH = 128,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// hold the last read word until the next read
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ufc_ctrl.sv @@
`timescale 1ns / 1ps

module ufc_ctrl
	import ufc_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF,
	localparam int RA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1,
	localparam int TA = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [2:0]    req_type,
	input  logic [7:0]    data_byte,
	input  logic [2:0]    error_status,
	output logic          rx_we,
	output logic          rx_re,
	output logic [RA-1:0] rx_addr,
	output logic          tx_we,
	output logic          tx_re,
	output logic [TA-1:0] tx_addr,
	output logic [7:0]    wdata,
	output step_t         step
);

	localparam logic [RA-1:0] RX_LAST = RA'(RX_DEPTH - 1);
	localparam logic [TA-1:0] TX_LAST = TA'(TX_DEPTH - 1);

	logic [RA-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [TA-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic          tx_idle_q, tx_idle_d;
	logic [2:0]    last_err_q, last_err_d;
	logic [15:0]   err_cnt_q, err_cnt_d;
	logic [RA-1:0] rx_head_nx, rx_tail_nx;
	logic [TA-1:0] tx_head_nx, tx_tail_nx;
	logic          rx_empty, rx_full, tx_empty, tx_full;

	assign rx_head_nx = (rx_head_q == RX_LAST) ? '0 : rx_head_q + RA'(1);
	assign rx_tail_nx = (rx_tail_q == RX_LAST) ? '0 : rx_tail_q + RA'(1);
	assign tx_head_nx = (tx_head_q == TX_LAST) ? '0 : tx_head_q + TA'(1);
	assign tx_tail_nx = (tx_tail_q == TX_LAST) ? '0 : tx_tail_q + TA'(1);
	assign rx_empty   = (rx_head_q == rx_tail_q);
	assign rx_full    = (rx_head_nx == rx_tail_q);
	assign tx_empty   = (tx_head_q == tx_tail_q);
	assign tx_full    = (tx_head_nx == tx_tail_q);

	always_comb begin
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		tx_idle_d  = tx_idle_q;
		last_err_d = last_err_q;
		err_cnt_d  = err_cnt_q;
		rx_we      = 1'b0;
		rx_re      = 1'b0;
		rx_addr    = rx_tail_q;
		tx_we      = 1'b0;
		tx_re      = 1'b0;
		tx_addr    = tx_tail_q;
		step       = '0;
		case (req_type)
			REQ_HOST_READ: begin
				if (!rx_empty) begin
					rx_re       = 1'b1;
					rx_tail_d   = rx_tail_nx;
					step.ok     = 1'b1;
					step.use_rx = 1'b1;
				end
			end
			REQ_HOST_WRITE: begin
				if (tx_idle_q) begin
					tx_idle_d     = 1'b0;
					step.ok       = 1'b1;
					step.shift    = 1'b1;
					step.byte_val = data_byte;
				end else if (!tx_full) begin
					tx_we     = 1'b1;
					tx_addr   = tx_head_q;
					tx_head_d = tx_head_nx;
					step.ok   = 1'b1;
				end
			end
			REQ_LINE_BYTE: begin
				// drop the byte silently when the ring is full
				if (!rx_full) begin
					rx_we     = 1'b1;
					rx_addr   = rx_head_q;
					rx_head_d = rx_head_nx;
					step.ok   = 1'b1;
				end
			end
			REQ_TX_DONE: begin
				if (!tx_empty) begin
					tx_re       = 1'b1;
					tx_tail_d   = tx_tail_nx;
					step.shift  = 1'b1;
					step.use_tx = 1'b1;
				end else begin
					tx_idle_d = 1'b1;
				end
			end
			REQ_RX_ERROR: begin
				if (error_status[0]) begin
					last_err_d = ERR_FRAMING;
				end else if (error_status[1]) begin
					last_err_d = ERR_PARITY;
				end else if (error_status[2]) begin
					last_err_d = ERR_OVERRUN;
				end else begin
					last_err_d = ERR_UNKNOWN;
				end
				err_cnt_d = err_cnt_q + 16'd1;
			end
			REQ_RESTART: begin
				rx_head_d = '0;
				rx_tail_d = '0;
				tx_head_d = '0;
				tx_tail_d = '0;
				tx_idle_d = 1'b1;
			end
			default: begin
			end
		endcase
		step.idle      = tx_idle_d && (tx_head_d == tx_tail_d);
		step.err_code  = last_err_d;
		step.err_total = err_cnt_d;
		rx_we = rx_we && accept;
		rx_re = rx_re && accept;
		tx_we = tx_we && accept;
		tx_re = tx_re && accept;
	end

	assign wdata = data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			tx_idle_q  <= 1'b1;
			last_err_q <= ERR_NONE;
			err_cnt_q  <= '0;
		end else if (accept) begin
			rx_head_q  <= rx_head_d;
			rx_tail_q  <= rx_tail_d;
			tx_head_q  <= tx_head_d;
			tx_tail_q  <= tx_tail_d;
			tx_idle_q  <= tx_idle_d;
			last_err_q <= last_err_d;
			err_cnt_q  <= err_cnt_d;
		end
	end

endmodule

@@ sv/uart_buffered_fifo_controller.sv @@
`timescale 1ns / 1ps

// Buffering core of a UART: a receive ring and a transmit ring, each in a
// synchronous byte memory, plus the transmitter idle flag and error record.
// Request channel (req_valid / req_stall): req_type selects host read, host
// write, line byte received, transmit done, receive error or restart;
// data_byte and error_status travel with it. Every request yields exactly one
// result on the response channel (rsp_valid / rsp_stall): ok, read_byte,
// shift_valid, shift_byte, tx_idle_flag, last_error_code and error_total.
// A request is decided when it is accepted and moves into the read stage,
// where the ring entry being popped is read, then into the response register.
// Throughput: one request per cycle while the response is not stalled, set by
// the single port of each ring memory: one read or one write per request.
// A stalled response holds; one further request may sit in the read stage,
// after which req_stall rises until the response is taken.
// Reset clears the ring pointers, the error record and count, and sets the
// transmitter idle; ring contents are left as they are.

module uart_buffered_fifo_controller
	import ufc_pkg::*;
#(
	parameter int RX_DEPTH = RX_DEPTH_DEF,
	parameter int TX_DEPTH = TX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  error_status,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        ok,
	output logic [7:0]  read_byte,
	output logic        shift_valid,
	output logic [7:0]  shift_byte,
	output logic        tx_idle_flag,
	output logic [2:0]  last_error_code,
	output logic [15:0] error_total
);

	localparam int RA = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TA = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

	logic          accept;
	logic          advance;
	logic          rx_we, rx_re, tx_we, tx_re;
	logic [RA-1:0] rx_addr;
	logic [TA-1:0] tx_addr;
	logic [7:0]    wdata, rx_rdata, tx_rdata;
	step_t         step;

	// read stage: request decided, ring byte on its way out of memory
	logic          valid_s1;
	step_t         step_s1;

	// response register
	logic          rsp_valid_q;
	step_t         rsp_step_q;
	logic [7:0]    read_byte_q;
	logic [7:0]    shift_byte_q;

	// Advance the read stage when the response register is free or being taken.
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	ufc_ctrl #(
		.RX_DEPTH (RX_DEPTH),
		.TX_DEPTH (TX_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req_type     (req_type),
		.data_byte    (data_byte),
		.error_status (error_status),
		.rx_we        (rx_we),
		.rx_re        (rx_re),
		.rx_addr      (rx_addr),
		.tx_we        (tx_we),
		.tx_re        (tx_re),
		.tx_addr      (tx_addr),
		.wdata        (wdata),
		.step         (step)
	);

	ufc_ring_mem #(
		.DEPTH (RX_DEPTH)
	) u_rx_mem (
		.clk   (clk),
		.we    (rx_we),
		.re    (rx_re),
		.addr  (rx_addr),
		.wdata (wdata),
		.rdata (rx_rdata)
	);

	ufc_ring_mem #(
		.DEPTH (TX_DEPTH)
	) u_tx_mem (
		.clk   (clk),
		.we    (tx_we),
		.re    (tx_re),
		.addr  (tx_addr),
		.wdata (wdata),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset, load only on their own handshake.
	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1 <= step;
		end
		if (advance) begin
			rsp_step_q   <= step_s1;
			read_byte_q  <= step_s1.use_rx ? rx_rdata : 8'd0;
			shift_byte_q <= step_s1.use_tx ? tx_rdata : step_s1.byte_val;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign ok              = rsp_step_q.ok;
	assign read_byte       = read_byte_q;
	assign shift_valid     = rsp_step_q.shift;
	assign shift_byte      = shift_byte_q;
	assign tx_idle_flag    = rsp_step_q.idle;
	assign last_error_code = rsp_step_q.err_code;
	assign error_total     = rsp_step_q.err_total;

	// An accepted request always occupies the read stage next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted request lost before the read stage");

	// A request held in the read stage keeps its decision.
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(step_s1)))
		else $error("read stage changed while held");

	// A byte handed to the shifter leaves the transmitter busy.
	a_shift_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && shift_valid) |-> !tx_idle_flag)
		else $error("transmitter reported idle after a hand-off");

endmodule

@@ verif/uart_buffer_checker.sv @@
`timescale 1ns / 1ps

module uart_buffer_checker
	import ufc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  data_byte,
	input  logic [2:0]  error_status,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        ok,
	input  logic [7:0]  read_byte,
	input  logic        shift_valid,
	input  logic [7:0]  shift_byte,
	input  logic        tx_idle_flag,
	input  logic [2:0]  last_error_code,
	input  logic [15:0] error_total,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic        ok;
		logic [7:0]  read_byte;
		logic        shift_valid;
		logic [7:0]  shift_byte;
		logic        tx_idle;
		logic [2:0]  err_code;
		logic [15:0] err_total;
	} uart_result_t;

	logic [7:0]   rx_ring [RX_DEPTH_DEF];
	logic [7:0]   tx_ring [TX_DEPTH_DEF];
	int unsigned  rx_wr, rx_rd, tx_wr, tx_rd;
	logic         tx_quiet;
	logic [2:0]   err_last;
	logic [15:0]  err_count;
	uart_result_t pending_results [$];
	int           mismatch_count = 0;

	assign mismatches = mismatch_count;

	function automatic int unsigned ring_advance(int unsigned ptr, int unsigned depth);
		return (ptr + 1 >= depth) ? 0 : ptr + 1;
	endfunction

	// Apply one request to the buffer state and return the response it gives.
	function automatic uart_result_t buffer_step(logic [2:0] kind, logic [7:0] value,
			logic [2:0] status);
		uart_result_t r;
		int unsigned  nxt;
		r = '0;
		case (kind)
			REQ_HOST_READ: if (rx_wr != rx_rd) begin
				r.read_byte = rx_ring[rx_rd];
				rx_rd = ring_advance(rx_rd, RX_DEPTH_DEF);
				r.ok = 1'b1;
			end
			REQ_HOST_WRITE: if (tx_quiet) begin
				tx_quiet = 1'b0;
				r.shift_valid = 1'b1;
				r.shift_byte = value;
				r.ok = 1'b1;
			end else begin
				nxt = ring_advance(tx_wr, TX_DEPTH_DEF);
				if (nxt != tx_rd) begin
					tx_ring[tx_wr] = value;
					tx_wr = nxt;
					r.ok = 1'b1;
				end
			end
			REQ_LINE_BYTE: begin
				nxt = ring_advance(rx_wr, RX_DEPTH_DEF);
				if (nxt != rx_rd) begin
					rx_ring[rx_wr] = value;
					rx_wr = nxt;
					r.ok = 1'b1;
				end
			end
			REQ_TX_DONE: if (tx_wr != tx_rd) begin
				r.shift_valid = 1'b1;
				r.shift_byte = tx_ring[tx_rd];
				tx_rd = ring_advance(tx_rd, TX_DEPTH_DEF);
			end else begin
				tx_quiet = 1'b1;
			end
			REQ_RX_ERROR: begin
				if (status[0])
					err_last = ERR_FRAMING;
				else if (status[1])
					err_last = ERR_PARITY;
				else if (status[2])
					err_last = ERR_OVERRUN;
				else
					err_last = ERR_UNKNOWN;
				err_count = err_count + 16'd1;
			end
			REQ_RESTART: begin
				rx_wr = 0;
				rx_rd = 0;
				tx_wr = 0;
				tx_rd = 0;
				tx_quiet = 1'b1;
			end
			default: ;
		endcase
		r.tx_idle = tx_quiet && (tx_wr == tx_rd);
		r.err_code = err_last;
		r.err_total = err_count;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	task automatic compare_field(input string name, input logic [15:0] seen,
			input logic [15:0] wanted);
		if (seen !== wanted)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, wanted));
	endtask

	always @(posedge clk or negedge arst_n) begin
		uart_result_t want;
		if (!arst_n) begin
			rx_wr = 0;
			rx_rd = 0;
			tx_wr = 0;
			tx_rd = 0;
			tx_quiet = 1'b1;
			err_last = ERR_NONE;
			err_count = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("response with no request waiting");
				end else begin
					want = pending_results.pop_front();
					compare_field("ok", 16'(ok), 16'(want.ok));
					compare_field("read_byte", 16'(read_byte), 16'(want.read_byte));
					compare_field("shift_valid", 16'(shift_valid), 16'(want.shift_valid));
					compare_field("shift_byte", 16'(shift_byte), 16'(want.shift_byte));
					compare_field("tx_idle_flag", 16'(tx_idle_flag), 16'(want.tx_idle));
					compare_field("last_error_code", 16'(last_error_code),
						16'(want.err_code));
					compare_field("error_total", error_total, want.err_total);
				end
			end
			if (req_valid && !req_stall)
				pending_results.push_back(buffer_step(req_type, data_byte, error_status));
			outstanding <= pending_results.size();
		end
	end

endmodule

@@ verif/tb_uart_buffered_fifo_controller.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the UART buffering core. The checker beside the
// block watches both channels, predicts every response and counts mismatches;
// this module only makes requests, stalls the response side and decides.

module tb_uart_buffered_fifo_controller;
	import ufc_pkg::*;

	// Request codes the block must leave without effect
	localparam logic [2:0] REQ_SPARE_LO = 3'd6;
	localparam logic [2:0] REQ_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  req_type = REQ_HOST_READ;
	logic [7:0]  data_byte = 8'h00;
	logic [2:0]  error_status = 3'b000;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        ok;
	logic [7:0]  read_byte;
	logic        shift_valid;
	logic [7:0]  shift_byte;
	logic        tx_idle_flag;
	logic [2:0]  last_error_code;
	logic [15:0] error_total;

	int mismatches;
	int outstanding;

	// Idle chance per cycle, in percent, for each side
	int req_idle_pct = 0;
	int rsp_stall_pct = 0;

	// Requests accepted, spare codes left out
	int requests_sent = 0;

	uart_buffered_fifo_controller DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.data_byte       (data_byte),
		.error_status    (error_status),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.ok              (ok),
		.read_byte       (read_byte),
		.shift_valid     (shift_valid),
		.shift_byte      (shift_byte),
		.tx_idle_flag    (tx_idle_flag),
		.last_error_code (last_error_code),
		.error_total     (error_total)
	);

	uart_buffer_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.req_type        (req_type),
		.data_byte       (data_byte),
		.error_status    (error_status),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.ok              (ok),
		.read_byte       (read_byte),
		.shift_valid     (shift_valid),
		.shift_byte      (shift_byte),
		.tx_idle_flag    (tx_idle_flag),
		.last_error_code (last_error_code),
		.error_total     (error_total),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Stall the response side at random; a fresh draw every cycle spreads the
	// stalls over every stage of the block's pipeline.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// Offer one request and hold it until the block takes it. While the sender
	// idles, drop valid and scramble data_byte, which the block must ignore.
	// Valid is never lowered and raised in the same step: an idle stretch
	// always waits on the clock before the request goes up again.
	task automatic send_request(input logic [2:0] kind, input logic [7:0] value,
			input logic [2:0] status);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			data_byte <= 8'($urandom);
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= kind;
		data_byte <= value;
		error_status <= status;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (kind <= REQ_RESTART)
			requests_sent++;
	endtask

	// Drop valid and hold off until every predicted response has come back.
	// The checker's count is registered, so wait on the clock before looking.
	task automatic wait_for_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// Random traffic in bursts: long runs of one request kind push the rings
	// to full and back to empty, so refusals, drops and idle hand-offs all
	// happen; mixed stretches and the odd restart cover the rest.
	task automatic random_bursts(input int quota);
		int start;
		int pick;
		int n;
		logic [2:0] kind;
		start = requests_sent;
		while (requests_sent - start < quota) begin
			pick = $urandom_range(99);
			n = $urandom_range(20, 140);
			if (pick < 20) begin
				repeat (n) send_request(REQ_LINE_BYTE, 8'($urandom), 3'($urandom));
			end else if (pick < 40) begin
				repeat (n) send_request(REQ_HOST_READ, 8'($urandom), 3'($urandom));
			end else if (pick < 55) begin
				repeat (n) send_request(REQ_HOST_WRITE, 8'($urandom), 3'($urandom));
			end else if (pick < 70) begin
				repeat (n) send_request(REQ_TX_DONE, 8'($urandom), 3'($urandom));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 6))
					send_request(REQ_RX_ERROR, 8'($urandom), 3'($urandom));
			end else if (pick < 83) begin
				send_request(REQ_RESTART, 8'($urandom), 3'($urandom));
			end else begin
				repeat (n / 4 + 5) begin
					if ($urandom_range(99) < 5)
						kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
					else
						kind = 3'($urandom_range(REQ_HOST_READ, REQ_RESTART));
					send_request(kind, 8'($urandom), 3'($urandom));
				end
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First idling phase covers the directed requests as well
		req_idle_pct = 35;
		rsp_stall_pct = 80;

		// Empty rings: read finds nothing, transmit done leaves the line idle
		send_request(REQ_HOST_READ, 8'h00, 3'b000);
		send_request(REQ_TX_DONE, 8'h00, 3'b000);
		// Idle transmitter takes the first write straight away, then queue two
		send_request(REQ_HOST_WRITE, 8'h00, 3'b000);
		send_request(REQ_HOST_WRITE, 8'hFF, 3'b111);
		send_request(REQ_HOST_WRITE, 8'hA5, 3'b000);
		// Drain the queue, then one more done marks the transmitter idle
		repeat (3) send_request(REQ_TX_DONE, 8'h00, 3'b000);
		// Line bytes at the extremes, read back, then read on empty
		send_request(REQ_LINE_BYTE, 8'h00, 3'b000);
		send_request(REQ_LINE_BYTE, 8'hFF, 3'b000);
		send_request(REQ_LINE_BYTE, 8'h5A, 3'b000);
		repeat (4) send_request(REQ_HOST_READ, 8'h00, 3'b000);
		// Every status pattern: unknown, then framing over parity over overrun
		for (int s = 0; s < 8; s++)
			send_request(REQ_RX_ERROR, 8'h00, 3'(s));
		// Spare codes must change nothing
		send_request(REQ_SPARE_LO, 8'hFF, 3'b111);
		send_request(REQ_SPARE_HI, 8'h00, 3'b000);
		// Restart with both rings holding bytes and the transmitter busy
		send_request(REQ_LINE_BYTE, 8'h3C, 3'b000);
		send_request(REQ_HOST_WRITE, 8'hC3, 3'b000);
		send_request(REQ_HOST_WRITE, 8'h81, 3'b000);
		send_request(REQ_RESTART, 8'h00, 3'b000);
		send_request(REQ_HOST_READ, 8'h00, 3'b000);
		send_request(REQ_TX_DONE, 8'h00, 3'b000);

		// Pause the sender until every response is back
		wait_for_responses();
		random_bursts(500);
		wait_for_responses();

		req_idle_pct = 80;
		rsp_stall_pct = 35;
		random_bursts(500);
		wait_for_responses();

		req_idle_pct = 0;
		rsp_stall_pct = 0;
		random_bursts(500);

		wait_for_responses();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_uart_buffered_fifo_controller: PASS");
		else
			$display("tb_uart_buffered_fifo_controller: FAIL");
		$finish;
	end

	// Hard stop well beyond the slowest correct run
	initial begin
		#2000000;
		$display("tb_uart_buffered_fifo_controller: FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/ufc_pkg.sv
sv/ufc_ring_mem.sv
sv/ufc_ctrl.sv
sv/uart_buffered_fifo_controller.sv
verif/uart_buffer_checker.sv
verif/tb_uart_buffered_fifo_controller.sv
